@@ design/orv_pkg.sv @@
// ----------------------------------------------------------------------------
// orv_pkg: shared types and constants of the object record validator
//
// Holds the header layout constants, the byte role and verdict codes and the
// per-byte result record that the parser hands to the output stage.
// ----------------------------------------------------------------------------
package orv_pkg;

  // Header layout: magic, version, reserved, attribute count, body, total.
  localparam int unsigned HdrBytes      = 20;
  localparam int unsigned AttrHdrShift  = 3;   // log2 of 8 bytes per attribute header

  // Byte address of the expected version register.
  localparam logic [2:0] VersionAddr = 3'd0;

  // Magic "P11O", element 0 is the first stored byte.
  localparam logic [3:0][7:0] MagicBytes = {8'h4F, 8'h31, 8'h31, 8'h50};

  // Byte role codes.
  localparam logic [2:0] RoleHeader   = 3'd0;
  localparam logic [2:0] RoleAttrType = 3'd1;
  localparam logic [2:0] RoleAttrLen  = 3'd2;
  localparam logic [2:0] RoleAttrVal  = 3'd3;
  localparam logic [2:0] RoleBody     = 3'd4;
  localparam logic [2:0] RoleRejected = 3'd5;

  // Verdict codes.
  localparam logic [1:0] VerdictParsing  = 2'd0;
  localparam logic [1:0] VerdictAccepted = 2'd1;
  localparam logic [1:0] VerdictRejected = 2'd2;

  // Per-byte result produced by the parser.
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [28:0] attr_number;
    logic [31:0] attr_type;
    logic [31:0] attr_len;
    logic [1:0]  verdict;
  } result_t;

endpackage

@@ design/orv_parser.sv @@
// ----------------------------------------------------------------------------
// orv_parser: record parse state and per-byte checks
//
// Holds the parse state of the current record and updates it by one byte on
// each step. The result for that byte is computed in the same cycle.
// ----------------------------------------------------------------------------
module orv_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [15:0]         version_i,
  output orv_pkg::result_t    result_o
);

  // Parse phase codes.
  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhType   = 3'd1;
  localparam logic [2:0] PhLen    = 3'd2;
  localparam logic [2:0] PhValue  = 3'd3;
  localparam logic [2:0] PhBody   = 3'd4;

  logic [31:0] byte_count_q, byte_count_d;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] field_shift_q, field_shift_d;
  logic [31:0] record_total_q, record_total_d;
  logic [31:0] attr_total_q, attr_total_d;
  logic [31:0] body_size_q, body_size_d;
  logic [29:0] attrs_seen_q, attrs_seen_d;
  logic [31:0] value_rem_q, value_rem_d;
  logic [31:0] cur_type_q, cur_type_d;
  logic        rejected_q, rejected_d;

  logic [4:0]  hpos;
  logic [29:0] attrs_inc;
  logic        attrs_done;
  logic        accept_ok;

  // OR one byte into a little-endian word at the given byte lane.
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [7:0] b,
                                           input logic [1:0] lane);
    logic [31:0] ext;
    ext = {24'd0, b};
    return word | (ext << {lane, 3'b000});
  endfunction

  assign hpos       = byte_count_q[4:0];
  assign attrs_inc  = attrs_seen_q + 30'd1;
  assign attrs_done = ({2'b00, attrs_inc} == attr_total_q);

  // Next state and result for the byte at the input.
  always_comb begin
    byte_count_d   = byte_count_q;
    phase_d        = phase_q;
    field_shift_d  = field_shift_q;
    record_total_d = record_total_q;
    attr_total_d   = attr_total_q;
    body_size_d    = body_size_q;
    attrs_seen_d   = attrs_seen_q;
    value_rem_d    = value_rem_q;
    cur_type_d     = cur_type_q;
    rejected_d     = rejected_q;
    result_o.byte_role   = orv_pkg::RoleRejected;
    result_o.attr_number = '0;
    result_o.attr_type   = '0;
    result_o.attr_len    = '0;

    if (!rejected_q) begin
      // Saturating byte count and the total length bound.
      if (byte_count_q == '1) begin
        rejected_d = 1'b1;
      end else begin
        byte_count_d = byte_count_q + 32'd1;
      end
      if (byte_count_q >= 32'(orv_pkg::HdrBytes) && byte_count_q >= record_total_q) begin
        rejected_d = 1'b1;
      end

      unique case (phase_q)
        PhHeader: begin
          result_o.byte_role = orv_pkg::RoleHeader;
          if (hpos < 5'd4) begin
            if (byte_i != orv_pkg::MagicBytes[hpos[1:0]]) rejected_d = 1'b1;
          end else if (hpos == 5'd4) begin
            if (byte_i != version_i[7:0]) rejected_d = 1'b1;
          end else if (hpos == 5'd5) begin
            if (byte_i != version_i[15:8]) rejected_d = 1'b1;
          end else if (hpos < 5'd8) begin
            if (byte_i != 8'd0) rejected_d = 1'b1;
          end else if (hpos < 5'd12) begin
            attr_total_d = put_byte(attr_total_q, byte_i, hpos[1:0]);
          end else if (hpos < 5'd16) begin
            body_size_d = put_byte(body_size_q, byte_i, hpos[1:0]);
          end else begin
            record_total_d = put_byte(record_total_q, byte_i, hpos[1:0]);
          end
          // Last header byte: bound the attribute count by the total length.
          if (hpos == 5'(orv_pkg::HdrBytes - 1)) begin
            if (record_total_d < 32'(orv_pkg::HdrBytes) ||
                attr_total_q > ((record_total_d - 32'(orv_pkg::HdrBytes))
                                >> orv_pkg::AttrHdrShift)) begin
              rejected_d = 1'b1;
            end
            attrs_seen_d  = '0;
            field_shift_d = '0;
            cur_type_d    = '0;
            if (attr_total_q == 32'd0) begin
              phase_d     = PhBody;
              value_rem_d = body_size_q;
            end else begin
              phase_d     = PhType;
              value_rem_d = '0;
            end
          end
        end
        PhType: begin
          result_o.byte_role   = orv_pkg::RoleAttrType;
          result_o.attr_number = attrs_seen_q[28:0];
          cur_type_d = put_byte(cur_type_q, byte_i, field_shift_q[1:0]);
          if (field_shift_q[1:0] == 2'd3) begin
            phase_d       = PhLen;
            field_shift_d = '0;
            value_rem_d   = '0;
          end else begin
            field_shift_d = field_shift_q + 32'd1;
          end
        end
        PhLen: begin
          result_o.byte_role   = orv_pkg::RoleAttrLen;
          result_o.attr_number = attrs_seen_q[28:0];
          result_o.attr_type   = cur_type_q;
          value_rem_d = put_byte(value_rem_q, byte_i, field_shift_q[1:0]);
          if (field_shift_q[1:0] == 2'd3) begin
            field_shift_d = value_rem_d;
            if (value_rem_d != 32'd0) begin
              phase_d = PhValue;
            end else begin
              // Empty value: the attribute ends here.
              attrs_seen_d = attrs_inc;
              if (attrs_done) begin
                phase_d     = PhBody;
                value_rem_d = body_size_q;
              end else begin
                phase_d       = PhType;
                field_shift_d = '0;
                cur_type_d    = '0;
                value_rem_d   = '0;
              end
            end
          end else begin
            field_shift_d = field_shift_q + 32'd1;
          end
        end
        PhValue: begin
          result_o.byte_role   = orv_pkg::RoleAttrVal;
          result_o.attr_number = attrs_seen_q[28:0];
          result_o.attr_type   = cur_type_q;
          result_o.attr_len    = field_shift_q;
          if (value_rem_q != 32'd0) value_rem_d = value_rem_q - 32'd1;
          if (value_rem_d == 32'd0) begin
            attrs_seen_d = attrs_inc;
            if (attrs_done) begin
              phase_d     = PhBody;
              value_rem_d = body_size_q;
            end else begin
              phase_d       = PhType;
              field_shift_d = '0;
              cur_type_d    = '0;
              value_rem_d   = '0;
            end
          end
        end
        default: begin
          result_o.byte_role   = orv_pkg::RoleBody;
          result_o.attr_number = attrs_seen_q[28:0];
          if (value_rem_q == 32'd0) begin
            rejected_d = 1'b1;
          end else begin
            value_rem_d = value_rem_q - 32'd1;
          end
        end
      endcase
    end

    // Verdict from the updated state.
    accept_ok = (phase_d == PhBody) && (value_rem_d == 32'd0) &&
                (byte_count_d == record_total_d);
    if (rejected_d) begin
      result_o.verdict = orv_pkg::VerdictRejected;
    end else if (last_i) begin
      result_o.verdict = accept_ok ? orv_pkg::VerdictAccepted : orv_pkg::VerdictRejected;
    end else begin
      result_o.verdict = orv_pkg::VerdictParsing;
    end

    // The final byte returns the parser to its reset state.
    if (last_i) begin
      byte_count_d   = '0;
      phase_d        = PhHeader;
      field_shift_d  = '0;
      record_total_d = '0;
      attr_total_d   = '0;
      body_size_d    = '0;
      attrs_seen_d   = '0;
      value_rem_d    = '0;
      cur_type_d     = '0;
      rejected_d     = 1'b0;
    end
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      phase_q        <= PhHeader;
      field_shift_q  <= '0;
      record_total_q <= '0;
      attr_total_q   <= '0;
      body_size_q    <= '0;
      attrs_seen_q   <= '0;
      value_rem_q    <= '0;
      cur_type_q     <= '0;
      rejected_q     <= 1'b0;
    end else if (step_i) begin
      byte_count_q   <= byte_count_d;
      phase_q        <= phase_d;
      field_shift_q  <= field_shift_d;
      record_total_q <= record_total_d;
      attr_total_q   <= attr_total_d;
      body_size_q    <= body_size_d;
      attrs_seen_q   <= attrs_seen_d;
      value_rem_q    <= value_rem_d;
      cur_type_q     <= cur_type_d;
      rejected_q     <= rejected_d;
    end
  end

  // A rejection holds until the record ends.
  a_reject_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected_q && !(step_i && last_i) |=> rejected_q)
    else $error("rejection cleared before end of record");

  // A record boundary leaves a fresh parser behind.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> !rejected_q && byte_count_q == 32'd0 && phase_q == PhHeader)
    else $error("parser state not cleared after final byte");

  // Acceptance is only given on the final byte.
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.verdict == orv_pkg::VerdictAccepted |-> last_i)
    else $error("accept verdict on a non-final byte");

  // The header phase never runs past the header length.
  a_header_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> byte_count_q < 32'(orv_pkg::HdrBytes))
    else $error("header phase beyond header length");

endmodule

@@ design/object_record_validator.sv @@
// ----------------------------------------------------------------------------
// object_record_validator: streaming object record format checker
//
// Path: each byte passes the input register and then the result register before
// it is offered at the output. Throughput: one byte per cycle while the output
// accepts; the parse state is updated once per byte, so bytes may arrive back to
// back while the output is being drained.
// Reset: all parse state cleared, expected_version set to 1, no output valid.
// ----------------------------------------------------------------------------
module object_record_validator (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  // Output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [7:0] byte_echo, [36:8] attr_number,
                                       // [68:37] attr_type, [100:69] attr_len,
                                       // [102:101] verdict, [103] zero
  output logic [2:0]   m_axis_tuser,   // [2:0] byte_role
  output logic         m_axis_tlast,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        advance;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  orv_pkg::result_t out_res_q;
  orv_pkg::result_t parse_res;

  logic [15:0] version_q;
  logic        reg_sel;

  // Configuration register, a single word at offset zero.
  assign pready  = 1'b1;
  assign reg_sel = (paddr == orv_pkg::VersionAddr);
  assign prdata  = reg_sel ? {16'd0, version_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 16'd1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      version_q <= pwdata[15:0];
    end
  end

  // The held byte moves on when the output register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  orv_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .version_i (version_q),
    .result_o  (parse_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_last_q <= in_last_q;
      out_res_q  <= parse_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_res_q.byte_role;
  assign m_axis_tdata  = {1'b0, out_res_q.verdict, out_res_q.attr_len,
                          out_res_q.attr_type, out_res_q.attr_number, out_byte_q};

endmodule
